@@ hw/rtl/iopsb_pkg.sv @@
// Shared types and constants for the I/O port and serial bridge.
package iopsb_pkg;

  localparam int PORT_COUNT = 7;
  localparam int PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] OFF_DIR    = 4'h8;
  localparam logic [3:0] OFF_CMD    = 4'h9;
  localparam logic [3:0] OFF_SDATA  = 4'ha;
  localparam logic [3:0] OFF_CMDRB  = 4'hb;
  localparam logic [3:0] OFF_SIN    = 4'hc;
  localparam logic [3:0] OFF_STATUS = 4'hd;

  localparam logic [7:0] CMD_ADDR_LO = 8'h00;
  localparam logic [7:0] CMD_ADDR_HI = 8'h01;
  localparam logic [7:0] CMD_SWRITE  = 8'h07;
  localparam logic [4:0] CMD_FIXED   = 5'b01110;

  localparam logic [7:0] STATUS_VALUE = 8'h08;
  localparam logic [7:0] UNUSED_READ  = 8'hff;

  localparam logic [1:0] EV_READ   = 2'd0;
  localparam logic [1:0] EV_DRIVE  = 2'd1;
  localparam logic [1:0] EV_SERIAL = 2'd2;

  typedef enum logic [1:0] {
    JOB_READ,
    JOB_DRIVE,
    JOB_SERIAL
  } job_kind_t;

  typedef struct packed {
    job_kind_t                        kind;
    logic [7:0]                       read_data;
    logic [15:0]                      serial_addr;
    logic [7:0]                       serial_data;
    logic [PORT_COUNT-1:0]            mask;
    logic [PORT_COUNT-1:0][7:0]       values;
  } job_t;

endpackage

@@ hw/rtl/io_port_and_serial_bridge_core.sv @@
// Top level of the I/O port and serial bridge: front, job queue and back.
// Result jobs pass through the job queue and the back output register. The front
// takes one item per cycle while the queue is not full; a direction write yields
// a result per re-driven port, and the two-entry job queue absorbs the difference.
// Reset clears port latches, direction, data, command and address registers,
// the job queue and the output valid.
module io_port_and_serial_bridge_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [3:0]  offset,
  input  logic [7:0]  write_data,
  input  logic [7:0]  pin_data,
  input  logic [7:0]  serial_rdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_res,
  output logic [7:0]  read_data,
  output logic [2:0]  port_index,
  output logic [7:0]  drive_value,
  output logic [15:0] serial_addr,
  output logic [7:0]  serial_data,
  output logic        last
);
  import iopsb_pkg::*;

  logic accept;
  logic push;
  logic full;
  logic empty;
  logic pop;
  job_t push_job;
  job_t head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  iopsb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (kind),
    .offset       (offset),
    .write_data   (write_data),
    .pin_data     (pin_data),
    .serial_rdata (serial_rdata),
    .push         (push),
    .push_job     (push_job)
  );

  iopsb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  iopsb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .read_data   (read_data),
    .port_index  (port_index),
    .drive_value (drive_value),
    .serial_addr (serial_addr),
    .serial_data (serial_data),
    .last        (last)
  );

endmodule

@@ hw/rtl/iopsb_queue.sv @@
// Short job queue between the front and back parts.
module iopsb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  iopsb_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output iopsb_pkg::job_t head
);
  import iopsb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

@@ hw/rtl/iopsb_front.sv @@
// Front part: takes bus items, keeps register state and queues result jobs.
module iopsb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            kind,
  input  logic [3:0]      offset,
  input  logic [7:0]      write_data,
  input  logic [7:0]      pin_data,
  input  logic [7:0]      serial_rdata,
  output logic            push,
  output iopsb_pkg::job_t push_job
);
  import iopsb_pkg::*;

  logic [7:0]            port_latch [PORT_COUNT];
  logic [7:0]            direction_bits;
  logic [7:0]            serial_data_reg;
  logic [7:0]            command_reg;
  logic [15:0]           serial_address;

  logic                  port_hit;
  logic [PORT_IDX_W-1:0] pidx;
  logic                  want;
  job_t                  job;

  assign port_hit = (offset < 4'(PORT_COUNT));
  assign pidx     = offset[PORT_IDX_W-1:0];

  always_comb begin
    job  = '0;
    want = 1'b0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      job.values[p] = port_latch[p];
    end
    if (!kind) begin
      want     = 1'b1;
      job.kind = JOB_READ;
      if (port_hit) begin
        job.read_data = direction_bits[offset[2:0]] ? pin_data : port_latch[pidx];
      end else begin
        case (offset)
          OFF_DIR:    job.read_data = direction_bits;
          OFF_SDATA:  job.read_data = serial_data_reg;
          OFF_CMDRB:  job.read_data = command_reg;
          OFF_SIN: begin
            job.read_data   = serial_rdata;
            job.serial_addr = serial_address;
          end
          OFF_STATUS: job.read_data = STATUS_VALUE;
          default:    job.read_data = UNUSED_READ;
        endcase
      end
    end else if (port_hit) begin
      want              = 1'b1;
      job.kind          = JOB_DRIVE;
      job.mask[pidx]    = 1'b1;
      job.values[pidx]  = write_data;
    end else begin
      case (offset)
        OFF_DIR: begin
          job.kind = JOB_DRIVE;
          job.mask = direction_bits[PORT_COUNT-1:0] & ~write_data[PORT_COUNT-1:0];
          want     = |job.mask;
        end
        OFF_CMD: begin
          job.kind        = JOB_SERIAL;
          job.serial_data = serial_data_reg;
          if (write_data == CMD_SWRITE) begin
            want            = 1'b1;
            job.serial_addr = serial_address;
          end else if (write_data[7:3] == CMD_FIXED) begin
            want            = 1'b1;
            job.serial_addr = {13'd0, write_data[2:0]};
          end
        end
        default: want = 1'b0;
      endcase
    end
  end

  assign push     = accept && want;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        port_latch[p] <= '0;
      end
      direction_bits  <= '0;
      serial_data_reg <= '0;
      command_reg     <= '0;
      serial_address  <= '0;
    end else if (accept && kind) begin
      if (port_hit) begin
        port_latch[pidx] <= write_data;
      end else begin
        case (offset)
          OFF_DIR:   direction_bits  <= write_data;
          OFF_SDATA: serial_data_reg <= write_data;
          OFF_CMD: begin
            command_reg <= write_data;
            if (write_data == CMD_ADDR_LO) begin
              serial_address[7:0] <= serial_data_reg;
            end else if (write_data == CMD_ADDR_HI) begin
              serial_address[15:8] <= serial_data_reg;
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_read_queued: assert property (@(posedge clk) disable iff (rst)
    accept && !kind |-> push)
    else $error("read item produced no job");
  a_drive_mask: assert property (@(posedge clk) disable iff (rst)
    push && job.kind == JOB_DRIVE |-> job.mask != '0)
    else $error("drive job with no port");
  a_dir_update: assert property (@(posedge clk) disable iff (rst)
    accept && kind && offset == OFF_DIR |=> direction_bits == $past(write_data))
    else $error("direction register not updated");

endmodule

@@ hw/rtl/iopsb_back.sv @@
// Back part: expands queued jobs into result items through an output register.
module iopsb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  iopsb_pkg::job_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      event_res,
  output logic [7:0]      read_data,
  output logic [2:0]      port_index,
  output logic [7:0]      drive_value,
  output logic [15:0]     serial_addr,
  output logic [7:0]      serial_data,
  output logic            last
);
  import iopsb_pkg::*;

  logic [PORT_COUNT-1:0] done;
  logic [PORT_COUNT-1:0] remaining;
  logic [PORT_COUNT-1:0] pick;
  logic [PORT_COUNT-1:0] rem_after;
  logic [PORT_IDX_W-1:0] pick_idx;
  logic                  load;
  logic                  final_drive;

  assign remaining = head.mask & ~done;

  always_comb begin
    pick     = '0;
    pick_idx = '0;
    for (int p = PORT_COUNT - 1; p >= 0; p--) begin
      if (remaining[p]) begin
        pick     = '0;
        pick[p]  = 1'b1;
        pick_idx = PORT_IDX_W'(p);
      end
    end
  end

  assign rem_after   = remaining & ~pick;
  assign final_drive = (rem_after == '0);
  assign load        = head_valid && (!out_valid || out_ready);
  assign pop         = load && (head.kind != JOB_DRIVE || final_drive);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        done <= '0;
      end else if (load) begin
        done <= done | pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      case (head.kind)
        JOB_READ: begin
          event_res   <= EV_READ;
          read_data   <= head.read_data;
          port_index  <= '0;
          drive_value <= '0;
          serial_addr <= head.serial_addr;
          serial_data <= '0;
          last        <= 1'b1;
        end
        JOB_DRIVE: begin
          event_res   <= EV_DRIVE;
          read_data   <= '0;
          port_index  <= 3'(pick_idx);
          drive_value <= head.values[pick_idx];
          serial_addr <= '0;
          serial_data <= '0;
          last        <= final_drive;
        end
        JOB_SERIAL: begin
          event_res   <= EV_SERIAL;
          read_data   <= '0;
          port_index  <= '0;
          drive_value <= '0;
          serial_addr <= head.serial_addr;
          serial_data <= head.serial_data;
          last        <= 1'b1;
        end
        default: begin
          event_res   <= EV_READ;
          read_data   <= '0;
          port_index  <= '0;
          drive_value <= '0;
          serial_addr <= '0;
          serial_data <= '0;
          last        <= 1'b1;
        end
      endcase
    end
  end

  a_drive_has_port: assert property (@(posedge clk) disable iff (rst)
    load && head.kind == JOB_DRIVE |-> remaining != '0)
    else $error("drive job exhausted before pop");
  a_done_subset: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (done & ~head.mask) == '0)
    else $error("emitted port outside job mask");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> done == '0)
    else $error("progress mask left over without a job");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_DRIVE |-> last)
    else $error("single-result item not marked last");

endmodule
